// File: hdl/mrfc_pkg.sv
// Package with the types, constants and CRC function of the meter response frame check.
`timescale 1ns / 1ps

package mrfc_pkg;

    localparam int RX_BYTE_W  = 8;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 7;
    localparam int CRC_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int CMD_W      = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Frames with this many accepted bytes or fewer are too short to check.
    localparam int MIN_LEN_FAIL = 6;

    localparam logic [CFG_IDX_W-1:0] REG_METER_ADDRESS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_SHORT = 3'd1;
    localparam status_t ST_CRC   = 3'd2;
    localparam status_t ST_ADDR  = 3'd3;
    localparam status_t ST_CMD   = 3'd4;

    typedef struct packed {
        logic [RX_BYTE_W-1:0] rx_byte;
        logic                 last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] meter_address;
        logic [CMD_W-1:0]  expected_command;
    } cfg_t;

    // One byte of the reflected CRC-16 update, one shift per bit.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [RX_BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-RX_BYTE_W){1'b0}}, b};
        for (int k = 0; k < RX_BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/mrfc_if.sv
// Channel interfaces for received bytes and frame check results.
`timescale 1ns / 1ps

interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface mrfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] frame_length;

    modport source (output valid, output status, output frame_length, input ready);
    modport sink (input valid, input status, input frame_length, output ready);
endinterface

// File: hdl/mrfc_in_reg.sv
// Input register that holds one received byte item until the checker takes it.
`timescale 1ns / 1ps

module mrfc_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    mrfc_in_if.sink             byte_ch,
    output mrfc_pkg::byte_item_t item,
    output logic                item_valid,
    input  logic                item_take
);
    import mrfc_pkg::*;

    byte_item_t item_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       load;

    assign byte_ch.ready = !valid_reg || item_take;
    assign load          = byte_ch.valid && byte_ch.ready;
    assign valid_next    = load || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.rx_byte   <= byte_ch.rx_byte;
            item_reg.last_byte <= byte_ch.last_byte;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: hdl/mrfc_check.sv
// Frame state, CRC update, status decision and result register.
`timescale 1ns / 1ps

module mrfc_check #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrfc_pkg::byte_item_t item,
    input  logic                 item_valid,
    output logic                 item_take,
    input  mrfc_pkg::cfg_t       cfg,
    mrfc_out_if.source           result_ch
);
    import mrfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [CRC_W-1:0]  crc_upd;
    logic [CRC_W-1:0]  held_reg;
    logic [CRC_W-1:0]  held_next;
    logic [CRC_W-1:0]  held_upd;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_upd;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] addr_upd;
    logic [CMD_W-1:0]  cmd_reg;
    logic [CMD_W-1:0]  cmd_next;
    logic [CMD_W-1:0]  cmd_upd;

    logic              room;
    logic [CRC_W-1:0]  rx_crc;
    status_t           status_calc;
    logic [EXT_W-1:0]  count_ext;
    logic              finish;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    logic [LEN_W-1:0]  len_reg;

    assign room = count_reg < CNT_W'(MAX_FRAME_BYTES);

    always_comb
    begin
        crc_upd   = crc_reg;
        held_upd  = held_reg;
        count_upd = count_reg;
        addr_upd  = addr_reg;
        cmd_upd   = cmd_reg;
        if (room)
        begin
            if (count_reg >= CNT_W'(2))
            begin
                crc_upd = crc_byte(crc_reg, held_reg[15:8]);
            end
            held_upd = {held_reg[7:0], item.rx_byte};
            if (count_reg < CNT_W'(4))
            begin
                addr_upd = {addr_reg[23:0], item.rx_byte};
            end
            else if (count_reg == CNT_W'(4))
            begin
                cmd_upd = item.rx_byte;
            end
            count_upd = count_reg + CNT_W'(1);
        end
    end

    // The CRC arrives low byte first, so the older held byte is the low half.
    assign rx_crc = {held_upd[7:0], held_upd[15:8]};

    always_comb
    begin
        if (count_upd <= CNT_W'(MIN_LEN_FAIL))
        begin
            status_calc = ST_SHORT;
        end
        else if (crc_upd != rx_crc)
        begin
            status_calc = ST_CRC;
        end
        else if (addr_upd != cfg.meter_address)
        begin
            status_calc = ST_ADDR;
        end
        else if (cmd_upd != cfg.expected_command)
        begin
            status_calc = ST_CMD;
        end
        else
        begin
            status_calc = ST_OK;
        end
    end

    assign count_ext = EXT_W'(count_upd);

    assign item_take = item_valid && (!item.last_byte || !out_valid_reg || result_ch.ready);
    assign finish    = item_take && item.last_byte;

    always_comb
    begin
        crc_next   = crc_reg;
        held_next  = held_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        if (finish)
        begin
            crc_next   = CRC_INIT;
            held_next  = '0;
            count_next = '0;
            addr_next  = '0;
            cmd_next   = '0;
        end
        else if (item_take)
        begin
            crc_next   = crc_upd;
            held_next  = held_upd;
            count_next = count_upd;
            addr_next  = addr_upd;
            cmd_next   = cmd_upd;
        end
    end

    assign out_valid_next = finish || (out_valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            held_reg      <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= status_calc;
            len_reg    <= count_ext[LEN_W-1:0];
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.status       = status_reg;
    assign result_ch.frame_length = len_reg;

endmodule

// File: hdl/meter_response_frame_check.sv
// Top level of the meter response frame check.
//
// Bytes of a meter reply frame enter on byte_ch, one item per byte, with
// last_byte set on the final byte of the frame. For each frame one item
// leaves on result_ch, carrying the status and the number of bytes counted.
// The expected address and command are written through the cfg_we,
// cfg_index and cfg_wdata port; the user must do so only while no frame
// is in flight, as the block does not enforce it. An accepted byte sits in
// the input register and is folded into the frame state when the checker
// takes it. Bytes are taken at one per cycle unless a stalled result holds
// back a last byte; the CRC step for one byte is combinational logic.
// Reset clears the frame state, the CRC to its initial value, both
// configuration registers and both valid flags.
// When the result receiver stalls, the pending result is held and bytes of
// the next frame keep flowing until a second last byte reaches the checker,
// which then waits for the result register to free up.
`timescale 1ns / 1ps

module meter_response_frame_check #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mrfc_in_if.sink                             byte_ch,
    mrfc_out_if.source                          result_ch,
    input  logic                                cfg_we,
    input  logic [mrfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mrfc_pkg::*;

    cfg_t       cfg_reg;
    byte_item_t item;
    logic       item_valid;
    logic       item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_METER_ADDRESS:    cfg_reg.meter_address    <= cfg_wdata[ADDR_W-1:0];
                REG_EXPECTED_COMMAND: cfg_reg.expected_command <= cfg_wdata[CMD_W-1:0];
                default:              ;
            endcase
        end
    end

    mrfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    mrfc_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .cfg        (cfg_reg),
        .result_ch  (result_ch)
    );

endmodule

// File: hdl/mrfc_checker.sv
// Port-level checks on the meter response frame check and their binding.
`timescale 1ns / 1ps

module mrfc_checker #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [6:0] frame_length
);
    import mrfc_pkg::*;

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_length))
        else $error("Result changed while stalled.");

    // With the result register empty, nothing can block the byte path.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Byte channel not ready with empty result register.");

    // A too-short status only comes with a short count.
    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SHORT |-> frame_length <= 7'd6)
        else $error("Too-short status with a long frame.");

    // Any other status needs a frame long enough to be checked.
    a_long_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_SHORT |-> (MAX_FRAME_BYTES > 127) || frame_length > 7'd6)
        else $error("Checked status with a short frame.");

endmodule

bind meter_response_frame_check mrfc_checker #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
) u_mrfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (byte_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .status       (result_ch.status),
    .frame_length (result_ch.frame_length)
);

// File: tb/testbench.sv
// Self-checking testbench for the meter response frame check: random frames against a predictor.
`timescale 1ns / 1ps

module testbench;
    import mrfc_pkg::*;

    localparam int MAX_BYTES = 64;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum int { FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_ADDR, FRAME_BAD_CMD,
                       FRAME_NOISE } frame_kind_t;

    typedef struct {
        status_t          status;
        logic [LEN_W-1:0] frame_length;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mrfc_in_if byte_ch ();
    mrfc_out_if result_ch ();

    meter_response_frame_check #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_ch(byte_ch),
        .result_ch(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Predictor copy of the configuration and of the frame state.
    logic [ADDR_W-1:0] meter_addr = '0;
    logic [CMD_W-1:0]  meter_cmd = '0;
    logic [CRC_W-1:0]  crc_run = CRC_INIT;
    logic [15:0]       tail_bytes = '0;
    int                frame_count = 0;
    logic [ADDR_W-1:0] addr_run = '0;
    logic [CMD_W-1:0]  cmd_run = '0;

    byte_item_t    pending_bytes[$];
    frame_result_t expected_results[$];
    byte_item_t    cur_byte;

    int items_queued = 0;
    int items_accepted = 0;
    int error_count = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_served = 0;
    bit src_idle_en = 1'b0;
    bit snk_idle_en = 1'b0;

    function automatic logic [CRC_W-1:0] modbus_crc_step(input logic [CRC_W-1:0] c,
                                                        input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic fold_byte(input byte_item_t it);
        frame_result_t r;
        if (frame_count < MAX_BYTES)
        begin
            if (frame_count >= 2)
            begin
                crc_run = modbus_crc_step(crc_run, tail_bytes[15:8]);
            end
            tail_bytes = {tail_bytes[7:0], it.rx_byte};
            if (frame_count < 4)
            begin
                addr_run = {addr_run[23:0], it.rx_byte};
            end
            else if (frame_count == 4)
            begin
                cmd_run = it.rx_byte;
            end
            frame_count++;
        end
        if (it.last_byte)
        begin
            if (frame_count <= MIN_LEN_FAIL)
            begin
                r.status = ST_SHORT;
            end
            else if (crc_run != {tail_bytes[7:0], tail_bytes[15:8]})
            begin
                r.status = ST_CRC;
            end
            else if (addr_run != meter_addr)
            begin
                r.status = ST_ADDR;
            end
            else if (cmd_run != meter_cmd)
            begin
                r.status = ST_CMD;
            end
            else
            begin
                r.status = ST_OK;
            end
            r.frame_length = LEN_W'(frame_count);
            expected_results.push_back(r);
            crc_run = CRC_INIT;
            tail_bytes = '0;
            frame_count = 0;
            addr_run = '0;
            cmd_run = '0;
        end
    endtask

    task automatic queue_frame(input int len, input frame_kind_t kind);
        logic [7:0] b[$];
        logic [ADDR_W-1:0] a;
        logic [CMD_W-1:0] cm;
        logic [CRC_W-1:0] c;
        byte_item_t it;
        int eff;
        int k;
        a = meter_addr;
        cm = meter_cmd;
        if (kind == FRAME_BAD_ADDR)
        begin
            a = a ^ (32'h1 << $urandom_range(0, 31));
        end
        if (kind == FRAME_BAD_CMD)
        begin
            cm = cm ^ (8'h1 << $urandom_range(0, 7));
        end
        eff = (len > MAX_BYTES) ? MAX_BYTES : len;
        for (int i = 0; i < len; i++)
        begin
            b.push_back(8'($urandom_range(0, 255)));
        end
        if (kind != FRAME_NOISE)
        begin
            for (int i = 0; i < 4 && i < eff; i++)
            begin
                b[i] = a[31 - 8 * i -: 8];
            end
            if (eff > 4)
            begin
                b[4] = cm;
            end
            if (eff > MIN_LEN_FAIL)
            begin
                c = CRC_INIT;
                for (int i = 0; i < eff - 2; i++)
                begin
                    c = modbus_crc_step(c, b[i]);
                end
                b[eff - 2] = c[7:0];
                b[eff - 1] = c[15:8];
                if (kind == FRAME_BAD_CRC)
                begin
                    k = eff - 1 - $urandom_range(0, 1);
                    b[k] = b[k] ^ (8'h1 << $urandom_range(0, 7));
                end
            end
        end
        for (int i = 0; i < len; i++)
        begin
            it.rx_byte = b[i];
            it.last_byte = (i == len - 1);
            pending_bytes.push_back(it);
            items_queued++;
        end
    endtask

    task automatic queue_random_frames(input int budget);
        int start;
        int r;
        int len;
        frame_kind_t kind;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                len = $urandom_range(1, MIN_LEN_FAIL);
            end
            else if (r < 88)
            begin
                len = $urandom_range(MIN_LEN_FAIL + 1, 14);
            end
            else if (r < 96)
            begin
                len = $urandom_range(15, MAX_BYTES);
            end
            else
            begin
                len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                kind = FRAME_GOOD;
            end
            else if (r < 67)
            begin
                kind = FRAME_BAD_CRC;
            end
            else if (r < 79)
            begin
                kind = FRAME_BAD_ADDR;
            end
            else if (r < 91)
            begin
                kind = FRAME_BAD_CMD;
            end
            else
            begin
                kind = FRAME_NOISE;
            end
            queue_frame(len, kind);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_METER_ADDRESS)
        begin
            meter_addr = val;
        end
        else
        begin
            meter_cmd = val[CMD_W-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Byte driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                fold_byte(cur_byte);
                items_accepted++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    byte_ch.valid <= 1'b0;
                end
                else if (src_idle_en && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 12);
                    byte_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    cur_byte = pending_bytes.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.rx_byte <= cur_byte.rx_byte;
                    byte_ch.last_byte <= cur_byte.last_byte;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver.
    frame_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("status with no frame pending", result_ch.status, -1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.status !== want.status)
                    begin
                        report_mismatch("status", result_ch.status, want.status);
                    end
                    if (result_ch.frame_length !== want.frame_length)
                    begin
                        report_mismatch("frame_length", result_ch.frame_length,
                                        want.frame_length);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_served != hold_req)
            begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                result_ch.ready <= 1'b0;
            end
            else if (snk_idle_en && $urandom_range(0, 5) == 0)
            begin
                snk_gap = $urandom_range(0, 12);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_METER_ADDRESS;
        cfg_wdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        write_reg(REG_METER_ADDRESS, $urandom);
        write_reg(REG_EXPECTED_COMMAND, $urandom_range(0, 255));
        queue_frame(1, FRAME_GOOD);
        queue_frame(MIN_LEN_FAIL, FRAME_GOOD);
        queue_frame(MIN_LEN_FAIL + 1, FRAME_GOOD);
        queue_frame(MIN_LEN_FAIL + 2, FRAME_BAD_CRC);
        queue_frame(MIN_LEN_FAIL + 1, FRAME_BAD_ADDR);
        queue_frame(MIN_LEN_FAIL + 1, FRAME_BAD_CMD);
        queue_frame(MAX_BYTES, FRAME_GOOD);
        queue_frame(MAX_BYTES + 6, FRAME_GOOD);
        wait_drained();

        snk_idle_en = 1'b0;
        write_reg(REG_METER_ADDRESS, '0);
        write_reg(REG_EXPECTED_COMMAND, '0);
        hold_req++;
        queue_random_frames(80);
        wait_drained();

        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        write_reg(REG_METER_ADDRESS, '1);
        write_reg(REG_EXPECTED_COMMAND, 32'hFF);
        queue_random_frames(40);
        wait_drained();
        queue_random_frames(40);
        wait_drained();

        snk_idle_en = 1'b0;
        write_reg(REG_METER_ADDRESS, $urandom);
        write_reg(REG_EXPECTED_COMMAND, $urandom_range(0, 255));
        queue_random_frames(70);
        wait_drained();

        repeat (20) @(negedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
